// File: sv/lert_pkg.sv
// shared types, constants and run summary merge for the longest equal run tree
package lert_pkg;

	localparam int IDX_BITS = 12;
	localparam int CAPACITY = 1 << IDX_BITS;
	localparam int SYM_BITS = 8;
	localparam int RUN_BITS = IDX_BITS + 1;
	localparam int HEAP_BITS = IDX_BITS + 2;
	localparam int LVL_BITS = 4;

	localparam logic OPC_WRITE = 1'b0;
	localparam logic OPC_QUERY = 1'b1;

	typedef logic [RUN_BITS-1:0] lert_run_t;
	typedef logic [IDX_BITS-1:0] lert_idx_t;
	typedef logic [SYM_BITS-1:0] lert_sym_t;

	typedef struct packed {
		lert_run_t pre;
		lert_run_t suf;
		lert_run_t best;
	} lert_sum_t;

	localparam lert_sum_t LEAF_SUM = '{pre: RUN_BITS'(1), suf: RUN_BITS'(1), best: RUN_BITS'(1)};

	typedef enum logic [1:0] {
		RSEL_WALK  = 2'd0,
		RSEL_LEFT  = 2'd1,
		RSEL_RIGHT = 2'd2,
		RSEL_FINAL = 2'd3
	} lert_rsel_t;

	typedef struct packed {
		logic       clr_wr;
		logic       load;
		logic       wsym;
		logic       walk_step;
		logic       left_step;
		logic       right_step;
		logic       shift;
		logic       final_step;
		logic       out_load;
		lert_rsel_t rsel;
	} lert_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic walk_last;
		logic l_gt_r;
		logic l_odd;
		logic r_even;
		logic out_busy;
	} lert_sts_t;

	function automatic lert_run_t lert_max(lert_run_t a, lert_run_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic lert_sum_t lert_join(lert_sum_t a, lert_run_t alen, lert_sum_t b,
		lert_run_t blen, logic same);
		lert_sum_t r;
		r.pre = a.pre;
		r.suf = b.suf;
		if (same) begin
			if (a.pre == alen) r.pre = a.pre + b.pre;
			if (b.suf == blen) r.suf = b.suf + a.suf;
		end
		r.best = lert_max(lert_max(a.best, b.best), lert_max(r.pre, r.suf));
		if (same) r.best = lert_max(r.best, a.suf + b.pre);
		return r;
	endfunction

	// span of heap node a, from the depth of its top bit
	function automatic lert_run_t lert_span(lert_idx_t a);
		lert_run_t sp;
		sp = '0;
		for (int i = 0; i < IDX_BITS; i++) begin
			if (a[i]) sp = RUN_BITS'(CAPACITY >> i);
		end
		return sp;
	endfunction

endpackage

// File: sv/lert_if.sv
// valid/ready channel interfaces for items and results
interface lert_in_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [lert_pkg::IDX_BITS-1:0] position;
	logic [lert_pkg::SYM_BITS-1:0] symbol;
	logic [lert_pkg::IDX_BITS-1:0] left_end;
	logic [lert_pkg::IDX_BITS-1:0] right_end;
	modport source (output valid, opcode, position, symbol, left_end, right_end, input ready);
	modport sink (input valid, opcode, position, symbol, left_end, right_end, output ready);
endinterface

interface lert_out_if;
	logic                      valid;
	logic                      ready;
	logic [lert_pkg::RUN_BITS-1:0] run_length;
	modport source (output valid, run_length, input ready);
	modport sink (input valid, run_length, output ready);
endinterface

// File: sv/longest_equal_run_range_tree_top.sv
// top level: longest equal run range query over a segment tree
// after reset a clearing pass over all 4096 entries runs before the first item is taken
// write: one read and one merge per tree level
// query: up to two node reads per level over 13 levels
// result register: the next item is taken while a result waits for transfer
// one item at a time; arst_n clears control state and restarts the clearing pass
module longest_equal_run_range_tree_top (
	input  logic clk,
	input  logic arst_n,
	lert_in_if.sink    items,
	lert_out_if.source results
);

	lert_pkg::lert_cmd_t cmd;
	lert_pkg::lert_sts_t sts;

	lert_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_opcode (items.opcode),
		.in_ready  (items.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lert_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_position    (items.position),
		.in_symbol      (items.symbol),
		.in_left_end    (items.left_end),
		.in_right_end   (items.right_end),
		.out_ready      (results.ready),
		.out_valid      (results.valid),
		.out_run_length (results.run_length)
	);

endmodule

// File: sv/lert_ctrl.sv
// controller state machine sequencing clear, update walk and range query
module lert_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_opcode,
	output logic                in_ready,
	input  lert_pkg::lert_sts_t sts,
	output lert_pkg::lert_cmd_t cmd
);

	typedef enum logic [14:0] {
		ST_CLEAR = 15'b000000000000001,
		ST_IDLE  = 15'b000000000000010,
		ST_WSYM  = 15'b000000000000100,
		ST_WRD   = 15'b000000000001000,
		ST_WUPD  = 15'b000000000010000,
		ST_QCHK  = 15'b000000000100000,
		ST_LRD   = 15'b000000001000000,
		ST_LUPD  = 15'b000000010000000,
		ST_RCHK  = 15'b000000100000000,
		ST_RRD   = 15'b000001000000000,
		ST_RUPD  = 15'b000010000000000,
		ST_SHIFT = 15'b000100000000000,
		ST_FRD   = 15'b001000000000000,
		ST_FUPD  = 15'b010000000000000,
		ST_OUT   = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rsel = lert_pkg::RSEL_WALK;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = (in_opcode == lert_pkg::OPC_WRITE) ? ST_WSYM : ST_QCHK;
				end
			end
			ST_WSYM: begin
				cmd.wsym = 1'b1;
				state_d = ST_WRD;
			end
			ST_WRD: state_d = ST_WUPD;
			ST_WUPD: begin
				cmd.walk_step = 1'b1;
				state_d = sts.walk_last ? ST_IDLE : ST_WRD;
			end
			ST_QCHK: begin
				if (sts.l_gt_r) state_d = ST_FRD;
				else if (sts.l_odd) state_d = ST_LRD;
				else state_d = ST_RCHK;
			end
			ST_LRD: begin
				cmd.rsel = lert_pkg::RSEL_LEFT;
				state_d = ST_LUPD;
			end
			ST_LUPD: begin
				cmd.left_step = 1'b1;
				state_d = ST_RCHK;
			end
			ST_RCHK: state_d = sts.r_even ? ST_RRD : ST_SHIFT;
			ST_RRD: begin
				cmd.rsel = lert_pkg::RSEL_RIGHT;
				state_d = ST_RUPD;
			end
			ST_RUPD: begin
				cmd.right_step = 1'b1;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				state_d = ST_QCHK;
			end
			ST_FRD: begin
				cmd.rsel = lert_pkg::RSEL_FINAL;
				state_d = ST_FUPD;
			end
			ST_FUPD: begin
				cmd.final_step = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// File: sv/lert_dp.sv
// datapath: symbol and node memories, index registers, merge unit, result register
module lert_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lert_pkg::lert_cmd_t cmd,
	output lert_pkg::lert_sts_t sts,
	input  logic [lert_pkg::IDX_BITS-1:0] in_position,
	input  logic [lert_pkg::SYM_BITS-1:0] in_symbol,
	input  logic [lert_pkg::IDX_BITS-1:0] in_left_end,
	input  logic [lert_pkg::IDX_BITS-1:0] in_right_end,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [lert_pkg::RUN_BITS-1:0] out_run_length
);

	lert_pkg::lert_sym_t sym_mem [lert_pkg::CAPACITY];
	lert_pkg::lert_sum_t nd_mem [lert_pkg::CAPACITY];

	lert_pkg::lert_idx_t clr_cnt_q;
	lert_pkg::lert_idx_t pos_q;
	lert_pkg::lert_sym_t sym_q;
	logic [lert_pkg::HEAP_BITS-1:0] l_q, r_q;
	logic [lert_pkg::RUN_BITS-1:0] lpos_q, rend_q;
	logic [lert_pkg::LVL_BITS-1:0] k_q;
	lert_pkg::lert_run_t len_q, lenl_q, lenr_q;
	lert_pkg::lert_sum_t accl_q, accr_q;
	logic accl_v_q, accr_v_q;
	lert_pkg::lert_run_t fin_q, res_q;
	logic out_valid_q;

	lert_pkg::lert_sym_t sym_a_q, sym_b_q;
	lert_pkg::lert_sum_t nd_q;

	lert_pkg::lert_idx_t ra, rb, nra, mid, lowmask, pmask;
	logic [lert_pkg::RUN_BITS-1:0] pm_wide;
	logic sym_we, nd_we;
	lert_pkg::lert_idx_t sym_wa, nd_wa;
	lert_pkg::lert_sym_t sym_wd;
	lert_pkg::lert_sum_t nd_wd, node_val, wl, wr, parent, fin_join;
	logic same;

	assign lowmask = len_q[lert_pkg::IDX_BITS-1:0] - lert_pkg::IDX_BITS'(1);
	assign pm_wide = {len_q[lert_pkg::IDX_BITS-1:0], 1'b0} - lert_pkg::RUN_BITS'(1);
	assign pmask = pm_wide[lert_pkg::IDX_BITS-1:0];
	assign mid = (pos_q & ~pmask) | lowmask;

	always_comb begin
		case (cmd.rsel)
			lert_pkg::RSEL_WALK: begin
				ra = mid;
				rb = mid + lert_pkg::IDX_BITS'(1);
				nra = l_q[lert_pkg::IDX_BITS-1:0] ^ lert_pkg::IDX_BITS'(1);
			end
			lert_pkg::RSEL_LEFT: begin
				ra = lpos_q[lert_pkg::IDX_BITS-1:0] - lert_pkg::IDX_BITS'(1);
				rb = lpos_q[lert_pkg::IDX_BITS-1:0];
				nra = l_q[lert_pkg::IDX_BITS-1:0];
			end
			lert_pkg::RSEL_RIGHT: begin
				ra = rend_q[lert_pkg::IDX_BITS-1:0];
				rb = rend_q[lert_pkg::IDX_BITS-1:0] + lert_pkg::IDX_BITS'(1);
				nra = r_q[lert_pkg::IDX_BITS-1:0];
			end
			lert_pkg::RSEL_FINAL: begin
				ra = lpos_q[lert_pkg::IDX_BITS-1:0] - lert_pkg::IDX_BITS'(1);
				rb = lpos_q[lert_pkg::IDX_BITS-1:0];
				nra = l_q[lert_pkg::IDX_BITS-1:0];
			end
			default: begin
				ra = mid;
				rb = mid;
				nra = '0;
			end
		endcase
	end

	assign same = (sym_a_q == sym_b_q);
	assign node_val = (k_q == '0) ? lert_pkg::LEAF_SUM : nd_q;
	assign wl = l_q[0] ? node_val : accl_q;
	assign wr = l_q[0] ? accl_q : node_val;
	assign parent = lert_pkg::lert_join(wl, len_q, wr, len_q, same);
	assign fin_join = lert_pkg::lert_join(accl_q, lenl_q, accr_q, lenr_q, same);

	always_comb begin
		sym_we = cmd.clr_wr | cmd.wsym;
		sym_wa = cmd.clr_wr ? clr_cnt_q : pos_q;
		sym_wd = cmd.clr_wr ? '0 : sym_q;
		nd_we = cmd.clr_wr | cmd.walk_step;
		nd_wa = cmd.clr_wr ? clr_cnt_q : l_q[lert_pkg::IDX_BITS:1];
		if (cmd.clr_wr) begin
			nd_wd.pre = lert_pkg::lert_span(clr_cnt_q);
			nd_wd.suf = nd_wd.pre;
			nd_wd.best = nd_wd.pre;
		end else begin
			nd_wd = parent;
		end
	end

	always_ff @(posedge clk) begin
		if (sym_we) sym_mem[sym_wa] <= sym_wd;
		sym_a_q <= sym_mem[ra];
		sym_b_q <= sym_mem[rb];
	end

	always_ff @(posedge clk) begin
		if (nd_we) nd_mem[nd_wa] <= nd_wd;
		nd_q <= nd_mem[nra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (cmd.clr_wr) clr_cnt_q <= clr_cnt_q + lert_pkg::IDX_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= in_position;
			sym_q <= in_symbol;
			l_q <= {2'b01, in_left_end};
			r_q <= {2'b01, in_right_end};
			lpos_q <= {1'b0, in_left_end};
			rend_q <= {1'b0, in_right_end};
			k_q <= '0;
			len_q <= lert_pkg::RUN_BITS'(1);
			lenl_q <= '0;
			lenr_q <= '0;
			accl_v_q <= 1'b0;
			accr_v_q <= 1'b0;
		end
		if (cmd.wsym) begin
			l_q <= {2'b01, pos_q};
			k_q <= '0;
			len_q <= lert_pkg::RUN_BITS'(1);
			accl_q <= lert_pkg::LEAF_SUM;
		end
		if (cmd.walk_step) begin
			accl_q <= parent;
			l_q <= {1'b0, l_q[lert_pkg::HEAP_BITS-1:1]};
			k_q <= k_q + lert_pkg::LVL_BITS'(1);
			len_q <= {len_q[lert_pkg::RUN_BITS-2:0], 1'b0};
		end
		if (cmd.left_step) begin
			accl_q <= accl_v_q ? lert_pkg::lert_join(accl_q, lenl_q, node_val, len_q, same)
				: node_val;
			accl_v_q <= 1'b1;
			lenl_q <= lenl_q + len_q;
			lpos_q <= lpos_q + len_q;
			l_q <= l_q + lert_pkg::HEAP_BITS'(1);
		end
		if (cmd.right_step) begin
			accr_q <= accr_v_q ? lert_pkg::lert_join(node_val, len_q, accr_q, lenr_q, same)
				: node_val;
			accr_v_q <= 1'b1;
			lenr_q <= lenr_q + len_q;
			rend_q <= rend_q - len_q;
			r_q <= r_q - lert_pkg::HEAP_BITS'(1);
		end
		if (cmd.shift) begin
			l_q <= {1'b0, l_q[lert_pkg::HEAP_BITS-1:1]};
			r_q <= {1'b0, r_q[lert_pkg::HEAP_BITS-1:1]};
			k_q <= k_q + lert_pkg::LVL_BITS'(1);
			len_q <= {len_q[lert_pkg::RUN_BITS-2:0], 1'b0};
		end
		if (cmd.final_step) begin
			if (accl_v_q && accr_v_q) begin
				fin_q <= fin_join.best;
			end else if (accl_v_q) begin
				fin_q <= accl_q.best;
			end else if (accr_v_q) begin
				fin_q <= accr_q.best;
			end else begin
				fin_q <= '0;
			end
		end
		if (cmd.out_load) res_q <= fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_run_length = res_q;

	assign sts.clear_last = (clr_cnt_q == lert_pkg::IDX_BITS'(lert_pkg::CAPACITY - 1));
	assign sts.walk_last = (k_q == lert_pkg::LVL_BITS'(lert_pkg::IDX_BITS - 1));
	assign sts.l_gt_r = (l_q > r_q);
	assign sts.l_odd = l_q[0];
	assign sts.r_even = ~r_q[0];
	assign sts.out_busy = out_valid_q & ~out_ready;

	a_left_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.left_step |-> (l_q <= r_q))
		else $error("left merge outside range");
	a_right_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.right_step |-> (l_q <= r_q))
		else $error("right merge outside range");
	a_walk_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> (k_q < lert_pkg::LVL_BITS'(lert_pkg::IDX_BITS)))
		else $error("update walk past root");
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result lost");

endmodule
